### src/qrs_pkg.sv
// shared types, widths and helper functions of the quadratic root solver
`default_nettype none
package qrs_pkg;

   localparam int COEF_WIDTH = 16;
   localparam int COEF_FRAC  = 8;
   localparam int ROOT_WIDTH = 32;
   localparam int ROOT_FRAC  = ROOT_WIDTH / 2;
   localparam int SQRT_EXTRA = 12;

   // discriminant and its magnitude
   localparam int PROD_W = 2 * COEF_WIDTH;
   localparam int DISC_W = PROD_W + 3;
   localparam int MAG_W  = PROD_W + 1;
   // square root of |d| * 2^(2*SQRT_EXTRA), i.e. sqrt(|d|) scaled by 2^SQRT_EXTRA
   localparam int SQRT_W = (MAG_W + 1) / 2 + SQRT_EXTRA;
   localparam int RAD_W  = 2 * SQRT_W;
   localparam int SREM_W = SQRT_W + 1;
   // numerators and denominator of the root parts
   localparam int NB_W   = COEF_WIDTH + 1 + SQRT_EXTRA;
   localparam int NUM_W  = SQRT_W + 2;
   localparam int MAGN_W = NUM_W - 1;
   localparam int DEN_W  = COEF_WIDTH + SQRT_EXTRA + 1;
   localparam int DVD_W  = MAGN_W + ROOT_FRAC;
   localparam int QBITS  = DVD_W - SQRT_EXTRA - 1;
   localparam int CMP_W  = ((QBITS > ROOT_WIDTH) ? QBITS : ROOT_WIDTH) + 1;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coef_a;
      logic signed [COEF_WIDTH-1:0] coef_b;
      logic signed [COEF_WIDTH-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic signed [ROOT_WIDTH-1:0] first_real;
      logic signed [ROOT_WIDTH-1:0] first_imag;
      logic signed [ROOT_WIDTH-1:0] second_real;
      logic signed [ROOT_WIDTH-1:0] second_imag;
      logic [1:0]                   real_count;
      logic                         degenerate;
      logic                         clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [NB_W-1:0] nb;
      logic                   a_neg;
      logic [DEN_W-1:0]       den;
      logic [1:0]             real_count;
      logic                   degenerate;
   } sqrt_side_type;

   typedef struct packed {
      logic       neg1;
      logic       neg2;
      logic       a_neg;
      logic [1:0] real_count;
      logic       degenerate;
   } root_side_type;

   typedef struct packed {
      logic [ROOT_WIDTH-1:0] value;
      logic                  clip;
   } root_part_type;

   // apply sign and clamp a quotient magnitude to the signed root range
   function automatic root_part_type to_root(input logic [QBITS-1:0] q, input logic neg);
      logic [CMP_W-1:0] lim;
      logic [CMP_W-1:0] qx;
      logic [CMP_W-1:0] qs;
      logic [CMP_W-1:0] v;
      root_part_type    r;
      lim = CMP_W'(1) << (ROOT_WIDTH - 1);
      if (!neg) begin
         lim = lim - CMP_W'(1);
      end
      qx = CMP_W'(q);
      r.clip = qx > lim;
      qs = r.clip ? lim : qx;
      v = neg ? (CMP_W'(0) - qs) : qs;
      r.value = v[ROOT_WIDTH-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### src/quadratic_root_solver_unit.sv
// top level of the quadratic root solver: discriminant, square root, dividers, clamp
//
//  port group   dir  handshake            payload
//  req_*        in   req_valid/req_ready  req_data  (coef_a, coef_b, coef_c)
//  rsp_*        out  rsp_valid/rsp_ready  rsp_data  (roots, real_count, flags)
//
// stages a and b feed the one-bit-per-stage square root, then stage c, the one-bit-per-stage
// dividers and the output register; one coefficient set per cycle is taken unless rsp stalls.
// reset clears only the valid bits of the stages, payload registers are not reset.
// the whole pipeline advances when the output register is empty or being taken;
// a stall on rsp freezes every stage, so nothing is lost or repeated.
`default_nettype none
module quadratic_root_solver_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire qrs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output qrs_pkg::rsp_type      rsp_data
);
   import qrs_pkg::*;

   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage a: products
   logic                         va_ff;
   logic signed [COEF_WIDTH-1:0] a_ff, b_ff;
   logic signed [PROD_W-1:0]     bb_ff, ac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
      end
      if (adv) begin
         a_ff  <= req_data.coef_a;
         b_ff  <= req_data.coef_b;
         bb_ff <= req_data.coef_b * req_data.coef_b;
         ac_ff <= req_data.coef_a * req_data.coef_c;
      end
   end

   // stage b: discriminant, sign class, -b and |2a| scaled
   logic signed [DISC_W-1:0]     d_w;
   logic [DISC_W-1:0]            dabs_w;
   logic signed [NB_W-1:0]       b_ext, a_ext, a_abs;
   sqrt_side_type                sside_in;
   logic                         vb_ff;
   logic [MAG_W-1:0]             dmag_ff;
   sqrt_side_type                sside_ff;

   always_comb begin
      d_w    = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
      dabs_w = d_w[DISC_W-1] ? (DISC_W'(0) - d_w) : d_w;
      b_ext  = NB_W'(b_ff);
      a_ext  = NB_W'(a_ff);
      a_abs  = a_ff[COEF_WIDTH-1] ? -a_ext : a_ext;
      sside_in.nb         = (-b_ext) <<< SQRT_EXTRA;
      sside_in.a_neg      = a_ff[COEF_WIDTH-1];
      sside_in.den        = DEN_W'(a_abs) << (SQRT_EXTRA + 1);
      sside_in.degenerate = a_ff == '0;
      priority if (a_ff == '0) begin
         sside_in.real_count = CNT_NONE;
      end else if (d_w[DISC_W-1]) begin
         sside_in.real_count = CNT_NONE;
      end else if (d_w == '0) begin
         sside_in.real_count = CNT_ONE;
      end else begin
         sside_in.real_count = CNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
      if (adv) begin
         dmag_ff  <= MAG_W'(dabs_w);
         sside_ff <= sside_in;
      end
   end

   // square root
   logic              vs_w;
   logic [SQRT_W-1:0] s_w;
   sqrt_side_type     sq_side_w;

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vb_ff),
      .in_mag    (dmag_ff),
      .in_side   (sside_ff),
      .out_valid (vs_w),
      .out_root  (s_w),
      .out_side  (sq_side_w)
   );

   // stage c: numerators as magnitude and sign
   logic signed [NUM_W-1:0] sx_w, nbx_w, n1_w, n2_w;
   logic                    vc_ff;
   logic [MAGN_W-1:0]       n1_ff, n2_ff, sm_ff;
   logic [DEN_W-1:0]        den_ff;
   root_side_type           rside_ff;

   always_comb begin
      nbx_w = NUM_W'(sq_side_w.nb);
      sx_w  = (sq_side_w.real_count == CNT_TWO) ? NUM_W'($signed({1'b0, s_w})) : '0;
      n1_w  = nbx_w - sx_w;
      n2_w  = nbx_w + sx_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vs_w;
      end
      if (adv) begin
         n1_ff  <= MAGN_W'(n1_w[NUM_W-1] ? -n1_w : n1_w);
         n2_ff  <= MAGN_W'(n2_w[NUM_W-1] ? -n2_w : n2_w);
         sm_ff  <= MAGN_W'(s_w);
         den_ff <= sq_side_w.den;
         rside_ff.neg1       <= n1_w[NUM_W-1] != sq_side_w.a_neg;
         rside_ff.neg2       <= n2_w[NUM_W-1] != sq_side_w.a_neg;
         rside_ff.a_neg      <= sq_side_w.a_neg;
         rside_ff.real_count <= sq_side_w.real_count;
         rside_ff.degenerate <= sq_side_w.degenerate;
      end
   end

   // three dividers in lockstep
   logic [QBITS-1:0] q1_w, q2_w, qs_w;

   qrs_div u_div_first (
      .clock (clock), .adv (adv),
      .num   ({n1_ff, ROOT_FRAC'(0)}), .den (den_ff), .quot (q1_w)
   );
   qrs_div u_div_second (
      .clock (clock), .adv (adv),
      .num   ({n2_ff, ROOT_FRAC'(0)}), .den (den_ff), .quot (q2_w)
   );
   qrs_div u_div_imag (
      .clock (clock), .adv (adv),
      .num   ({sm_ff, ROOT_FRAC'(0)}), .den (den_ff), .quot (qs_w)
   );

   // sideband and valid follow the divider stages
   root_side_type side_dly_ff [QBITS];
   logic          v_dly_ff    [QBITS];

   for (genvar k = 0; k < QBITS; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            v_dly_ff[k] <= 1'b0;
         end else if (adv) begin
            v_dly_ff[k] <= (k == 0) ? vc_ff : v_dly_ff[(k == 0) ? 0 : k-1];
         end
         if (adv) begin
            side_dly_ff[k] <= (k == 0) ? rside_ff : side_dly_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // stage d: sign, clamp and output register
   root_side_type side_w;
   root_part_type p1_w, p2_w, pi1_w, pi2_w;
   rsp_type       rsp_in;

   always_comb begin
      side_w = side_dly_ff[QBITS-1];
      p1_w   = to_root(q1_w, side_w.neg1);
      p2_w   = to_root(q2_w, side_w.neg2);
      pi1_w  = to_root(qs_w, !side_w.a_neg);
      pi2_w  = to_root(qs_w, side_w.a_neg);
      rsp_in.real_count = side_w.real_count;
      rsp_in.degenerate = side_w.degenerate;
      priority if (side_w.degenerate) begin
         rsp_in.first_real  = '0;
         rsp_in.first_imag  = '0;
         rsp_in.second_real = '0;
         rsp_in.second_imag = '0;
         rsp_in.clipped     = 1'b0;
      end else if (side_w.real_count == CNT_NONE) begin
         rsp_in.first_real  = p1_w.value;
         rsp_in.first_imag  = pi1_w.value;
         rsp_in.second_real = p2_w.value;
         rsp_in.second_imag = pi2_w.value;
         rsp_in.clipped     = p1_w.clip | p2_w.clip | pi1_w.clip | pi2_w.clip;
      end else begin
         rsp_in.first_real  = p1_w.value;
         rsp_in.first_imag  = '0;
         rsp_in.second_real = p2_w.value;
         rsp_in.second_imag = '0;
         rsp_in.clipped     = p1_w.clip | p2_w.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_dly_ff[QBITS-1];
      end
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.first_real == '0 && rsp_data.second_real == '0 &&
         rsp_data.real_count == CNT_NONE && !rsp_data.clipped)
      else $error("degenerate result carries nonzero roots");

   a_real_no_imag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.real_count != CNT_NONE |->
         rsp_data.first_imag == '0 && rsp_data.second_imag == '0)
      else $error("real roots with an imaginary part");

   a_double_equal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.real_count == CNT_ONE |->
         rsp_data.first_real == rsp_data.second_real)
      else $error("double root with differing parts");

   a_conjugate : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.real_count == CNT_NONE && !rsp_data.degenerate &&
      !rsp_data.clipped |->
         rsp_data.second_imag == -rsp_data.first_imag &&
         rsp_data.first_real == rsp_data.second_real)
      else $error("complex pair is not conjugate");

endmodule
`default_nettype wire

### src/qrs_sqrt.sv
// pipelined integer square root, one result bit per stage, sideband carried along
`default_nettype none
module qrs_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [qrs_pkg::MAG_W-1:0] in_mag,
   input  wire qrs_pkg::sqrt_side_type in_side,
   output logic                       out_valid,
   output logic [qrs_pkg::SQRT_W-1:0] out_root,
   output qrs_pkg::sqrt_side_type     out_side
);
   import qrs_pkg::*;

   logic [RAD_W-1:0]  rad_ff  [SQRT_W];
   logic [SREM_W-1:0] rem_ff  [SQRT_W];
   logic [SQRT_W-1:0] root_ff [SQRT_W];
   sqrt_side_type     side_ff [SQRT_W];
   logic              valid_ff [SQRT_W];

   for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
      logic [RAD_W-1:0]    rad_src;
      logic [SREM_W-1:0]   rem_src;
      logic [SQRT_W-1:0]   root_src;
      sqrt_side_type       side_src;
      logic                valid_src;
      logic [SREM_W+1:0]   remx;
      logic [SREM_W+1:0]   trial;
      logic                ge;
      logic [RAD_W-1:0]    rad_in;
      logic [SREM_W-1:0]   rem_in;
      logic [SQRT_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign rad_src   = RAD_W'(in_mag) << (2 * SQRT_EXTRA);
         assign rem_src   = '0;
         assign root_src  = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rad_src   = rad_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      always_comb begin
         remx    = {rem_src, rad_src[RAD_W-1 -: 2]};
         trial   = (SREM_W+2)'({root_src, 2'b01});
         ge      = remx >= trial;
         rem_in  = ge ? SREM_W'(remx - trial) : SREM_W'(remx);
         root_in = {root_src[SQRT_W-2:0], ge};
         rad_in  = rad_src << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_src;
         end
         if (adv) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_W-1];
   assign out_root  = root_ff[SQRT_W-1];
   assign out_side  = side_ff[SQRT_W-1];

endmodule
`default_nettype wire

### src/qrs_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module qrs_div (
   input  wire logic                     clock,
   input  wire logic                     adv,
   input  wire logic [qrs_pkg::DVD_W-1:0] num,
   input  wire logic [qrs_pkg::DEN_W-1:0] den,
   output logic [qrs_pkg::QBITS-1:0]     quot
);
   import qrs_pkg::*;

   logic [DEN_W-1:0] rem_ff [QBITS];
   logic [QBITS-1:0] low_ff [QBITS];
   logic [QBITS-1:0] q_ff   [QBITS];
   logic [DEN_W-1:0] den_ff [QBITS];

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [QBITS-1:0] low_src;
      logic [QBITS-1:0] q_src;
      logic [DEN_W-1:0] den_src;
      logic [DEN_W:0]   remx;
      logic             ge;

      if (k == 0) begin : g_first
         // high dividend bits are below the divisor whenever the divisor is nonzero
         assign rem_src = DEN_W'(num[DVD_W-1:QBITS]);
         assign low_src = num[QBITS-1:0];
         assign q_src   = '0;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      always_comb begin
         remx = {rem_src, low_src[QBITS-1]};
         ge   = remx >= {1'b0, den_src};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? DEN_W'(remx - {1'b0, den_src}) : DEN_W'(remx);
            low_ff[k] <= low_src << 1;
            q_ff[k]   <= {q_src[QBITS-2:0], ge};
            den_ff[k] <= den_src;
         end
      end
   end

   assign quot = q_ff[QBITS-1];

endmodule
`default_nettype wire
